// ----- sv/h264au_pkg.sv -----
// Shared types and constants for the H.264 Annex-B access unit splitter.
package h264au_pkg;

  // NAL unit type codes that steer unit boundaries.
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SEI   = 5'd6;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;
  localparam logic [4:0] NAL_AUD   = 5'd9;

  // Start code bytes.
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // Longest zero run that belongs to a start code.
  localparam logic [1:0] ZRUN_MAX = 2'd3;
  localparam logic [1:0] ZRUN_SC  = 2'd2;

  // Result queue geometry.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // One reported access unit.
  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic        has_idr;
    logic        final_unit;
  } res_t;

endpackage

// ----- sv/h264_annexb_access_unit_splitter.sv -----
// Top level of the H.264 Annex-B access unit splitter.
//
//  Channel  Dir  Handshake              Payload
//  in_      in   in_valid / in_ready    data_byte, end_of_stream
//  out_     out  out_valid / out_ready  unit_offset, unit_length, has_idr, final_unit
//
// One byte is taken per cycle while in_ready is high; the parser updates its
// state in the same cycle. Results land in a four-entry queue that drives out_.
// in_ready drops only while the queue holds more than two results, since one
// byte may add two (a closed unit and the final unit at end of stream).
// Reset is synchronous and active low and clears the parser and the queue.
module h264_annexb_access_unit_splitter #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_unit_offset,
  output logic [31:0] out_unit_length,
  output logic        out_has_idr,
  output logic        out_final_unit
);

  logic             beat_en;
  logic             room2;
  logic [1:0]       res_n;
  logic [1:0]       push_n;
  h264au_pkg::res_t res0, res1, rdata;

  assign in_ready = room2;
  assign beat_en  = in_valid && in_ready;
  assign push_n   = beat_en ? res_n : 2'd0;

  // Stream parser.
  h264au_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_en      (beat_en),
    .data_byte    (in_data_byte),
    .end_of_stream(in_end_of_stream),
    .res_n        (res_n),
    .res0         (res0),
    .res1         (res1)
  );

  // Result queue.
  h264au_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .wdata0   (res0),
    .wdata1   (res1),
    .room2    (room2),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rdata    (rdata)
  );

  assign out_unit_offset = rdata.unit_offset;
  assign out_unit_length = rdata.unit_length;
  assign out_has_idr     = rdata.has_idr;
  assign out_final_unit  = rdata.final_unit;

endmodule

// ----- sv/h264au_parser.sv -----
// Byte-wise start code, NAL header and access unit boundary tracker.
module h264au_parser #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_en,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_stream,
  output logic [1:0]           res_n,
  output h264au_pkg::res_t     res0,
  output h264au_pkg::res_t     res1
);

  localparam int unsigned W = OFFSET_BITS;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_SLICE1,
    PH_BODY
  } phase_t;

  phase_t       phase_r, phase_nxt, phase_mid;
  logic [W-1:0] pos_r, pos_nxt;
  logic [1:0]   zrun_r, zrun_nxt, zrun_mid;
  logic [4:0]   ntype_r, ntype_nxt, ntype_mid;
  logic [W-1:0] nal_start_r, nal_start_nxt, nal_start_mid;
  logic [W-1:0] unit_start_r, unit_start_nxt, unit_start_mid;
  logic         seen_r, seen_nxt, seen_mid;
  logic         idr_r, idr_nxt, idr_mid;
  logic         close_unit;
  logic         fin_unit;
  logic [W-1:0] sc_pos;
  logic [W-1:0] pos_inc;
  logic [W-1:0] close_len;
  logic [W-1:0] fin_len;
  logic [W+31:0] ext_close_off, ext_close_len, ext_fin_off, ext_fin_len;
  h264au_pkg::res_t close_res, fin_res;

  assign sc_pos  = pos_r - {{(W-2){1'b0}}, zrun_r};
  assign pos_inc = pos_r + {{(W-1){1'b0}}, 1'b1};

  // Per-byte update of the stream parser.
  always_comb begin
    phase_mid      = phase_r;
    zrun_mid       = zrun_r;
    ntype_mid      = ntype_r;
    nal_start_mid  = nal_start_r;
    unit_start_mid = unit_start_r;
    seen_mid       = seen_r;
    idr_mid        = idr_r;
    close_unit     = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        ntype_mid = data_byte[4:0];
        case (data_byte[4:0]) inside
          [h264au_pkg::NAL_SLICE:h264au_pkg::NAL_IDR]: begin
            phase_mid = PH_SLICE1;
          end
          h264au_pkg::NAL_SEI, h264au_pkg::NAL_SPS,
          h264au_pkg::NAL_PPS, h264au_pkg::NAL_AUD: begin
            close_unit = seen_r;
            phase_mid  = PH_BODY;
          end
          default: begin
            phase_mid = PH_BODY;
          end
        endcase
        zrun_mid = (data_byte == h264au_pkg::SC_ZERO) ? 2'd1 : 2'd0;
      end
      PH_SLICE1: begin
        // The leading ue(v) bit set means first_mb_in_slice is zero.
        close_unit = seen_r && data_byte[7];
        phase_mid  = PH_BODY;
        zrun_mid   = (data_byte == h264au_pkg::SC_ZERO) ? 2'd1 : 2'd0;
      end
      default: begin
        if ((data_byte == h264au_pkg::SC_ONE) && (zrun_r >= h264au_pkg::ZRUN_SC)) begin
          if (phase_r == PH_SEARCH) begin
            unit_start_mid = sc_pos;
          end
          nal_start_mid = sc_pos;
          phase_mid     = PH_HEADER;
          zrun_mid      = 2'd0;
        end else if (data_byte == h264au_pkg::SC_ZERO) begin
          if (zrun_r != h264au_pkg::ZRUN_MAX) begin
            zrun_mid = zrun_r + 2'd1;
          end
        end else begin
          zrun_mid = 2'd0;
        end
      end
    endcase

    // A closing unit ends where the new NAL's start code begins.
    if (close_unit) begin
      unit_start_mid = nal_start_r;
      idr_mid        = 1'b0;
      seen_mid       = 1'b0;
    end
    if (phase_r == PH_SLICE1) begin
      if (ntype_r == h264au_pkg::NAL_IDR) begin
        idr_mid = 1'b1;
      end
      seen_mid = 1'b1;
    end
  end

  // End of stream reports the open unit and returns to the reset state.
  assign fin_unit  = end_of_stream && (phase_mid != PH_SEARCH);
  assign close_len = nal_start_r - unit_start_r;
  assign fin_len   = pos_inc - unit_start_mid;

  assign ext_close_off = {32'd0, unit_start_r};
  assign ext_close_len = {32'd0, close_len};
  assign ext_fin_off   = {32'd0, unit_start_mid};
  assign ext_fin_len   = {32'd0, fin_len};

  always_comb begin
    close_res.unit_offset = ext_close_off[31:0];
    close_res.unit_length = ext_close_len[31:0];
    close_res.has_idr     = idr_r;
    close_res.final_unit  = 1'b0;
    fin_res.unit_offset   = ext_fin_off[31:0];
    fin_res.unit_length   = ext_fin_len[31:0];
    fin_res.has_idr       = idr_mid ||
                            ((phase_mid == PH_SLICE1) && (ntype_mid == h264au_pkg::NAL_IDR));
    fin_res.final_unit    = 1'b1;
  end

  always_comb begin
    res0  = close_unit ? close_res : fin_res;
    res1  = fin_res;
    res_n = {1'b0, close_unit} + {1'b0, fin_unit};
  end

  always_comb begin
    if (end_of_stream) begin
      phase_nxt      = PH_SEARCH;
      pos_nxt        = '0;
      zrun_nxt       = 2'd0;
      ntype_nxt      = 5'd0;
      nal_start_nxt  = '0;
      unit_start_nxt = '0;
      seen_nxt       = 1'b0;
      idr_nxt        = 1'b0;
    end else begin
      phase_nxt      = phase_mid;
      pos_nxt        = pos_inc;
      zrun_nxt       = zrun_mid;
      ntype_nxt      = ntype_mid;
      nal_start_nxt  = nal_start_mid;
      unit_start_nxt = unit_start_mid;
      seen_nxt       = seen_mid;
      idr_nxt        = idr_mid;
    end
  end

  // Parser state, updated once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      pos_r        <= '0;
      zrun_r       <= 2'd0;
      ntype_r      <= 5'd0;
      nal_start_r  <= '0;
      unit_start_r <= '0;
      seen_r       <= 1'b0;
      idr_r        <= 1'b0;
    end else if (beat_en) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      zrun_r       <= zrun_nxt;
      ntype_r      <= ntype_nxt;
      nal_start_r  <= nal_start_nxt;
      unit_start_r <= unit_start_nxt;
      seen_r       <= seen_nxt;
      idr_r        <= idr_nxt;
    end
  end

`ifndef SYNTHESIS
  // Two results on one beat only happen at end of stream.
  a_two_only_at_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_en && (res_n == 2'd2)) |-> end_of_stream)
    else $error("two results without end of stream");

  // End of stream restarts the offset count and the search.
  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_en && end_of_stream) |=> ((pos_r == '0) && (phase_r == PH_SEARCH)))
    else $error("state not cleared after end of stream");

  // A unit is only closed once a slice has been seen in it.
  a_close_needs_slice: assert property (@(posedge clk) disable iff (!rst_n)
    (beat_en && close_unit) |-> seen_r)
    else $error("unit closed without a slice");
`endif

endmodule

// ----- sv/h264au_fifo.sv -----
// Small result queue that takes up to two results per cycle and gives one while out_ready is high.
module h264au_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  h264au_pkg::res_t wdata0,
  input  h264au_pkg::res_t wdata1,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output h264au_pkg::res_t rdata
);

  h264au_pkg::res_t                    mem_r [h264au_pkg::Q_DEPTH];
  logic [h264au_pkg::Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [h264au_pkg::Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [h264au_pkg::Q_PTR_W-1:0]      wr_ptr_p1;
  logic [h264au_pkg::Q_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                                pop;

  localparam logic [h264au_pkg::Q_CNT_W-1:0] CNT_ROOM2 =
    h264au_pkg::Q_CNT_W'(h264au_pkg::Q_DEPTH - 2);
  localparam logic [h264au_pkg::Q_CNT_W-1:0] CNT_FULL =
    h264au_pkg::Q_CNT_W'(h264au_pkg::Q_DEPTH);

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign room2     = (cnt_r <= CNT_ROOM2);
  assign rdata     = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + {{(h264au_pkg::Q_PTR_W-1){1'b0}}, 1'b1};

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {{(h264au_pkg::Q_PTR_W-1){1'b0}}, pop};
    cnt_nxt    = cnt_r + {{(h264au_pkg::Q_CNT_W-2){1'b0}}, push_n}
                 - {{(h264au_pkg::Q_CNT_W-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= wdata0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_p1] <= wdata1;
    end
  end

`ifndef SYNTHESIS
  // The fill count never exceeds the queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("result queue overflow");

  // Pushes only arrive while there is room for two results.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room2)
    else $error("push without room");

  // Fill count tracks the pointers.
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[h264au_pkg::Q_PTR_W-1:0] == (wr_ptr_r - rd_ptr_r)))
    else $error("fill count disagrees with pointers");
`endif

endmodule

// ----- bench/tb_h264_annexb_access_unit_splitter.sv -----
// Self-checking testbench for the H.264 Annex-B access unit splitter.
module tb_h264_annexb_access_unit_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OFF_W        = 32;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          RANDOM_BYTES = 1300;
  localparam int          NOISE_BYTES  = 150;

  // Parser phases tracked by the predictor.
  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_FIRST_MB,
    PH_BODY
  } parse_phase_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte     = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [31:0] out_unit_offset;
  logic [31:0] out_unit_length;
  logic        out_has_idr;
  logic        out_final_unit;

  // Predictor state.
  logic [OFF_W-1:0] stream_pos;
  logic [1:0]       zero_count;
  parse_phase_t     phase;
  logic [4:0]       nal_kind;
  logic [OFF_W-1:0] nal_begin;
  logic [OFF_W-1:0] unit_begin;
  logic             slice_in_unit;
  logic             idr_in_unit;

  h264au_pkg::res_t units_due[$];
  logic [7:0]  stream_bytes[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  bit          in_gaps_on = 1'b0;
  bit          out_stalls_on = 1'b0;
  int          out_stall_left = 0;

  h264_annexb_access_unit_splitter #(
    .OFFSET_BITS(OFF_W)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_unit_offset  (out_unit_offset),
    .out_unit_length  (out_unit_length),
    .out_has_idr      (out_has_idr),
    .out_final_unit   (out_final_unit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic void clear_tracker();
    stream_pos    = '0;
    zero_count    = '0;
    phase         = PH_SEARCH;
    nal_kind      = '0;
    nal_begin     = '0;
    unit_begin    = '0;
    slice_in_unit = 1'b0;
    idr_in_unit   = 1'b0;
  endfunction

  function automatic void push_unit(logic [OFF_W-1:0] first, logic [OFF_W-1:0] past_end,
                                    logic key, logic fin);
    h264au_pkg::res_t u;
    logic [OFF_W-1:0] len;
    len           = past_end - first;
    u.unit_offset = 32'(first);
    u.unit_length = 32'(len);
    u.has_idr     = key;
    u.final_unit  = fin;
    units_due.push_back(u);
  endfunction

  // The open unit ends where the NAL now being parsed begins.
  function automatic void close_access_unit();
    push_unit(unit_begin, nal_begin, idr_in_unit, 1'b0);
    unit_begin    = nal_begin;
    idr_in_unit   = 1'b0;
    slice_in_unit = 1'b0;
  endfunction

  // Advance the predictor by one accepted byte and queue the units it closes.
  function automatic void track_stream_byte(logic [7:0] b, logic eos);
    logic [4:0] t;
    logic       key;
    t = b[4:0];
    if (phase == PH_HEADER) begin
      nal_kind = t;
      if (t >= h264au_pkg::NAL_SLICE && t <= h264au_pkg::NAL_IDR) begin
        phase = PH_FIRST_MB;
      end else begin
        if ((t == h264au_pkg::NAL_SEI || t == h264au_pkg::NAL_SPS ||
             t == h264au_pkg::NAL_PPS || t == h264au_pkg::NAL_AUD) && slice_in_unit)
          close_access_unit();
        phase = PH_BODY;
      end
      zero_count = (b == h264au_pkg::SC_ZERO) ? 2'd1 : 2'd0;
    end else if (phase == PH_FIRST_MB) begin
      // Bit 7 set means first_mb_in_slice is zero, i.e. a new picture.
      if (slice_in_unit && b[7]) close_access_unit();
      if (nal_kind == h264au_pkg::NAL_IDR) idr_in_unit = 1'b1;
      slice_in_unit = 1'b1;
      phase         = PH_BODY;
      zero_count    = (b == h264au_pkg::SC_ZERO) ? 2'd1 : 2'd0;
    end else begin
      if (b == h264au_pkg::SC_ONE && zero_count >= h264au_pkg::ZRUN_SC) begin
        nal_begin = stream_pos - OFF_W'(zero_count);
        if (phase == PH_SEARCH) unit_begin = nal_begin;
        phase      = PH_HEADER;
        zero_count = '0;
      end else if (b == h264au_pkg::SC_ZERO) begin
        if (zero_count < h264au_pkg::ZRUN_MAX) zero_count = zero_count + 2'd1;
      end else begin
        zero_count = '0;
      end
    end

    if (eos) begin
      if (phase != PH_SEARCH) begin
        key = idr_in_unit || (phase == PH_FIRST_MB && nal_kind == h264au_pkg::NAL_IDR);
        push_unit(unit_begin, stream_pos + OFF_W'(1), key, 1'b1);
      end
      clear_tracker();
    end else begin
      stream_pos = stream_pos + OFF_W'(1);
    end
  endfunction

  // Send one byte: optional idle gap, then hold the beat until it is taken.
  task automatic send_byte(logic [7:0] b, logic eos);
    int gap;
    gap = pick_gap(in_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_stream_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_stream(bit close_with_eos);
    int n;
    n = stream_bytes.size();
    for (int i = 0; i < n; i++)
      send_byte(stream_bytes[i], close_with_eos && (i == n - 1));
    stream_bytes.delete();
  endtask

  // Body bytes lean toward zeros and ones so that stray start codes show up.
  function automatic logic [7:0] pick_body_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return h264au_pkg::SC_ZERO;
    if (r == 3) return h264au_pkg::SC_ONE;
    return 8'($urandom);
  endfunction

  // Append one NAL: start code of two to five zeros, header, slice byte for slices, body.
  function automatic void append_nal(logic [4:0] t, logic pic_start);
    int         zeros;
    logic [7:0] hdr;
    logic [7:0] mb;
    int         body_len;
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 5) : $urandom_range(2, 3);
    repeat (zeros) stream_bytes.push_back(h264au_pkg::SC_ZERO);
    stream_bytes.push_back(h264au_pkg::SC_ONE);
    hdr      = 8'($urandom);
    hdr[4:0] = t;
    stream_bytes.push_back(hdr);
    if (t >= h264au_pkg::NAL_SLICE && t <= h264au_pkg::NAL_IDR) begin
      mb    = 8'($urandom);
      mb[7] = pic_start;
      stream_bytes.push_back(mb);
    end
    body_len = $urandom_range(0, 6);
    repeat (body_len) stream_bytes.push_back(pick_body_byte());
  endfunction

  // A stream that never holds a start code yields nothing.
  task automatic test_no_start_code();
    stream_bytes = '{8'hFF, h264au_pkg::SC_ZERO};
    send_stream(1'b1);
  endtask

  // A four-zero run before an SPS, then an IDR slice starting a picture.
  task automatic test_long_zero_run_and_idr();
    stream_bytes = '{h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO,
                     h264au_pkg::SC_ZERO, h264au_pkg::SC_ONE, 8'h67,
                     h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO, h264au_pkg::SC_ONE,
                     8'h65, 8'h88};
    send_stream(1'b0);
  endtask

  // An AUD after a slice closes the unit; the first slice's picture start closes none.
  task automatic test_unit_boundaries();
    stream_bytes = '{h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO, h264au_pkg::SC_ONE,
                     8'h41, 8'h9A,
                     h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO, h264au_pkg::SC_ONE,
                     8'h09};
    send_stream(1'b0);
  endtask

  // An IDR header on the last byte marks the final unit as a keyframe.
  task automatic test_slice_header_at_end();
    stream_bytes = '{h264au_pkg::SC_ZERO, h264au_pkg::SC_ZERO, h264au_pkg::SC_ONE,
                     8'h25};
    send_stream(1'b1);
  endtask

  // Well-formed streams of access units with random content and idling.
  task automatic test_random_access_units();
    int         units;
    int         slices;
    int         cut;
    int         mode;
    logic [4:0] slice_kind;
    while (bytes_sent < RANDOM_BYTES) begin
      mode          = $urandom_range(0, 3);
      in_gaps_on    = (mode == 0 || mode == 1);
      out_stalls_on = (mode == 0 || mode == 2);
      repeat ($urandom_range(0, 3)) stream_bytes.push_back(pick_body_byte());
      units = $urandom_range(1, 5);
      repeat (units) begin
        if ($urandom_range(0, 2) == 0) append_nal(h264au_pkg::NAL_AUD, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          append_nal(h264au_pkg::NAL_SPS, 1'b0);
          append_nal(h264au_pkg::NAL_PPS, 1'b0);
        end
        if ($urandom_range(0, 3) == 0) append_nal(h264au_pkg::NAL_SEI, 1'b0);
        if ($urandom_range(0, 7) == 0) append_nal(5'($urandom_range(10, 31)), 1'b0);
        if ($urandom_range(0, 15) == 0) append_nal(5'd0, 1'b0);
        slices = $urandom_range(1, 3);
        for (int s = 0; s < slices; s++) begin
          slice_kind = ($urandom_range(0, 2) == 0) ? h264au_pkg::NAL_IDR
                                                   : 5'($urandom_range(1, 4));
          append_nal(slice_kind, (s == 0) ? ($urandom_range(0, 9) != 0)
                                          : ($urandom_range(0, 6) == 0));
        end
      end
      // Some streams stop in the middle of a NAL.
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, stream_bytes.size());
        while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
      send_stream($urandom_range(0, 6) != 0);
    end
  endtask

  // Unstructured bytes with end of stream dropped in at random.
  task automatic test_random_noise();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (NOISE_BYTES) send_byte(pick_body_byte(), $urandom_range(0, 24) == 0);
  endtask

  // Result side stalls: ready is low for the length of each chosen stall.
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 30 && pick_gap(out_stalls_on) > 0) begin
      out_stall_left = pick_gap(1'b1);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every result beat with the oldest expected unit.
  always @(posedge clk) begin
    h264au_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (units_due.size() == 0) begin
        $error("unit with nothing expected: offset %0d length %0d",
               out_unit_offset, out_unit_length);
        fail_count++;
      end else begin
        want = units_due.pop_front();
        if (out_unit_offset !== want.unit_offset) begin
          $error("unit_offset: expected %0d, got %0d", want.unit_offset, out_unit_offset);
          fail_count++;
        end
        if (out_unit_length !== want.unit_length) begin
          $error("unit_length: expected %0d, got %0d", want.unit_length, out_unit_length);
          fail_count++;
        end
        if (out_has_idr !== want.has_idr) begin
          $error("has_idr: expected %0d, got %0d", want.has_idr, out_has_idr);
          fail_count++;
        end
        if (out_final_unit !== want.final_unit) begin
          $error("final_unit: expected %0d, got %0d", want.final_unit, out_final_unit);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_h264_annexb_access_unit_splitter: done, errors");
      $finish;
    end
  end

  initial begin
    clear_tracker();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    test_no_start_code();
    test_long_zero_run_and_idr();
    test_unit_boundaries();
    test_slice_header_at_end();
    test_random_access_units();
    test_random_noise();

    @(negedge clk);
    in_valid <= 1'b0;

    // Let every expected unit come out, then watch for strays.
    while (units_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && units_due.size() == 0) begin
      $display("tb_h264_annexb_access_unit_splitter: done, clean");
    end else begin
      $display("tb_h264_annexb_access_unit_splitter: done, errors");
    end
    $finish;
  end

endmodule
